// ===== rtl/core/fci_pkg.sv =====
package fci_pkg;

   localparam int CURVE_POINTS_DEFAULT = 10;
   localparam int CURVE_POINTS_MAX = 32;
   localparam int POINT_IDX_W = $clog2(CURVE_POINTS_MAX);

   localparam int TEMP_W = 8;
   localparam int LEVEL_W = 17;
   localparam int SAMPLE_W = 16;
   localparam int POINT_W = TEMP_W + LEVEL_W;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'h10000;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] REGION_INTERP = 2'd0;
   localparam logic [1:0] REGION_BELOW = 2'd1;
   localparam logic [1:0] REGION_ABOVE = 2'd2;
   localparam logic [1:0] REGION_FLAT = 2'd3;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic [LEVEL_W-1:0] level;
   } point_type;

   // Factory curve: 25 C to 70 C in 5 degree steps, 10 % to 100 % of full speed.
   function automatic point_type default_point(input logic [POINT_IDX_W-1:0] idx);
      point_type p;
      case (idx)
         5'd0: begin
            p.temp = 8'sd25; p.level = 17'd6554;
         end
         5'd1: begin
            p.temp = 8'sd30; p.level = 17'd13107;
         end
         5'd2: begin
            p.temp = 8'sd35; p.level = 17'd19661;
         end
         5'd3: begin
            p.temp = 8'sd40; p.level = 17'd26214;
         end
         5'd4: begin
            p.temp = 8'sd45; p.level = 17'd32768;
         end
         5'd5: begin
            p.temp = 8'sd50; p.level = 17'd39322;
         end
         5'd6: begin
            p.temp = 8'sd55; p.level = 17'd45875;
         end
         5'd7: begin
            p.temp = 8'sd60; p.level = 17'd52429;
         end
         5'd8: begin
            p.temp = 8'sd65; p.level = 17'd58982;
         end
         default: begin
            p.temp = 8'sd70; p.level = LEVEL_FULL;
         end
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/core/fci_ram.sv =====
module fci_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/fan_curve_interpolator.sv =====
// Channel   Ports                                         Direction
// request   start, busy, req_operation, req_entry_index,  in (busy out)
//           req_entry_temperature, req_entry_level,
//           req_temperature
// response  rsp_valid, rsp_fan_level, rsp_region          out
//
// A breakpoint write gives no response.
// An evaluation scans the curve with one memory read per breakpoint and either ends
// on the scan or interpolates with a multiply, the restoring divider and a final add.
// The response shows for one cycle, as busy falls; the receiver cannot stall it.
// Reset restores the factory curve at once through per-entry valid bits.
module fan_curve_interpolator #(
   parameter int CURVE_POINTS = fci_pkg::CURVE_POINTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic [3:0]                           req_entry_index,
   input  logic signed [fci_pkg::TEMP_W-1:0]    req_entry_temperature,
   input  logic [fci_pkg::LEVEL_W-1:0]          req_entry_level,
   input  logic signed [fci_pkg::SAMPLE_W-1:0]  req_temperature,
   output logic                                 rsp_valid,
   output logic [fci_pkg::LEVEL_W-1:0]          rsp_fan_level,
   output logic [1:0]                           rsp_region
);

   import fci_pkg::*;

   localparam int IDX_W = $clog2(CURVE_POINTS);
   localparam int CMP_W = $bits(req_entry_index) + 2;
   localparam int DIV_STEPS = LEVEL_W;
   localparam int DIVCNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_MUL = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;
   localparam logic [2:0] ST_FIN = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [CURVE_POINTS-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] pt_idx_ff, pt_idx_in;
   logic rd_def_ff;
   logic signed [SAMPLE_W-1:0] t_ff, t_in;
   logic signed [TEMP_W-1:0] lo_temp_ff, lo_temp_in, hi_temp_ff, hi_temp_in;
   logic [LEVEL_W-1:0] lo_level_ff, lo_level_in, hi_level_ff, hi_level_in;
   logic neg_ff, neg_in;
   logic [SAMPLE_W-1:0] div_ff, div_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [LEVEL_W-1:0] quo_ff, quo_in;
   logic [DIVCNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [1:0] rsp_region_ff, rsp_region_in;

   logic accept;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [POINT_W-1:0] wr_word;
   logic [POINT_W-1:0] rd_word;
   point_type wr_point;
   point_type cur;
   logic pt_last;
   logic signed [TEMP_W-1:0] cur_temp;
   logic signed [SAMPLE_W:0] offset;
   logic [LEVEL_W:0] diff;
   logic [LEVEL_W-1:0] mag;
   logic [TEMP_W:0] dt;
   logic [LEVEL_W+SAMPLE_W-1:0] product;
   logic [SAMPLE_W:0] trial;
   logic trial_ge;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);

   assign wr_en = accept && (req_operation == OP_WRITE)
                  && ({2'b00, req_entry_index} < CMP_W'(CURVE_POINTS));
   assign wr_addr = IDX_W'(req_entry_index);
   assign wr_point.temp = req_entry_temperature;
   assign wr_point.level = (req_entry_level > LEVEL_FULL) ? LEVEL_FULL : req_entry_level;
   assign wr_word = wr_point;

   assign pt_last = (pt_idx_ff == IDX_W'(CURVE_POINTS - 1));
   assign rd_addr = (state_ff == ST_IDLE || pt_last) ? '0 : pt_idx_ff + 1'b1;

   fci_ram #(
      .WIDTH(POINT_W),
      .DEPTH(CURVE_POINTS)
   ) u_fci_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_word),
      .rd_addr(rd_addr),
      .rd_data(rd_word)
   );

   // Entries never written since reset read as the factory curve.
   assign cur = rd_def_ff ? default_point(POINT_IDX_W'(pt_idx_ff)) : point_type'(rd_word);
   assign cur_temp = cur.temp;

   assign offset = {t_ff[SAMPLE_W-1], t_ff} - {lo_temp_ff[TEMP_W-1], lo_temp_ff, 8'h00};
   assign diff = {1'b0, hi_level_ff} - {1'b0, lo_level_ff};
   assign mag = diff[LEVEL_W] ? (lo_level_ff - hi_level_ff) : diff[LEVEL_W-1:0];
   assign dt = {hi_temp_ff[TEMP_W-1], hi_temp_ff} - {lo_temp_ff[TEMP_W-1], lo_temp_ff};
   assign product = (LEVEL_W+SAMPLE_W)'(mag) * (LEVEL_W+SAMPLE_W)'(offset[SAMPLE_W-1:0]);

   assign trial = {rem_ff, quo_ff[LEVEL_W-1]};
   assign trial_ge = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      pt_idx_in = pt_idx_ff;
      t_in = t_ff;
      lo_temp_in = lo_temp_ff;
      lo_level_in = lo_level_ff;
      hi_temp_in = hi_temp_ff;
      hi_level_in = hi_level_ff;
      neg_in = neg_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_level_in = rsp_level_ff;
      rsp_region_in = rsp_region_ff;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            pt_idx_in = '0;
            if (accept && req_operation == OP_EVAL) begin
               t_in = req_temperature;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pt_idx_in = rd_addr;
            if (pt_idx_ff == '0) begin
               lo_temp_in = cur.temp;
               lo_level_in = cur.level;
               if (t_ff <= $signed({cur_temp, 8'h00})) begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = cur.level;
                  rsp_region_in = REGION_BELOW;
                  state_in = ST_IDLE;
               end
            end else if (t_ff <= $signed({cur_temp, 8'h00})) begin
               hi_temp_in = cur.temp;
               hi_level_in = cur.level;
               if (lo_level_ff == cur.level) begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = lo_level_ff;
                  rsp_region_in = REGION_FLAT;
                  state_in = ST_IDLE;
               end else if (cur_temp <= lo_temp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = cur.level;
                  rsp_region_in = REGION_FLAT;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MUL;
               end
            end else begin
               lo_temp_in = cur.temp;
               lo_level_in = cur.level;
               if (pt_last) begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = cur.level;
                  rsp_region_in = REGION_ABOVE;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL: begin
            // The quotient never exceeds the level difference, so the upper
            // dividend bits already lie below the divisor.
            neg_in = diff[LEVEL_W];
            div_in = {dt[TEMP_W-1:0], 8'h00};
            rem_in = product[LEVEL_W+SAMPLE_W-1:LEVEL_W];
            quo_in = product[LEVEL_W-1:0];
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial_ge) begin
               rem_in = SAMPLE_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = trial[SAMPLE_W-1:0];
            end
            quo_in = {quo_ff[LEVEL_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIVCNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_level_in = neg_ff ? (lo_level_ff - quo_ff) : (lo_level_ff + quo_ff);
            rsp_region_in = REGION_INTERP;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_idx_ff <= pt_idx_in;
      rd_def_ff <= !valid_ff[rd_addr];
      t_ff <= t_in;
      lo_temp_ff <= lo_temp_in;
      lo_level_ff <= lo_level_in;
      hi_temp_ff <= hi_temp_in;
      hi_level_ff <= hi_level_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rsp_level_ff <= rsp_level_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fan_level = rsp_level_ff;
   assign rsp_region = rsp_region_ff;

endmodule

// ===== rtl/core/fci_checker.sv =====
module fci_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_operation,
   input logic                                rsp_valid,
   input logic [fci_pkg::LEVEL_W-1:0]         rsp_fan_level
);

   import fci_pkg::*;

   // A response appears only once the block has gone idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response shown while busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_WRITE) |=> (!busy && !rsp_valid))
      else $error("breakpoint write made the block busy or respond");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_EVAL) |=> (busy && !rsp_valid))
      else $error("evaluation did not start");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fan_level <= LEVEL_FULL))
      else $error("fan level above full speed");

endmodule

bind fan_curve_interpolator fci_checker u_fci_checker (.*);
